/* rtl/bmp_row_pixel_unpacker_macros.svh */
// Assertion macros shared by the pixel unpacker RTL.
`ifndef BMP_ROW_PIXEL_UNPACKER_MACROS_SVH
`define BMP_ROW_PIXEL_UNPACKER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define BRPU_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define BRPU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/brpu_pkg.sv */
// Types and constants for the BMP row pixel unpacker.
`timescale 1ns / 1ps

package brpu_pkg;

	// Palette store geometry
	localparam int PALETTE_DEPTH = 256;
	localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
	localparam int PAL_WIDTH     = 24;

	// Supported color depths
	localparam logic [5:0] BPP_1  = 6'd1;
	localparam logic [5:0] BPP_4  = 6'd4;
	localparam logic [5:0] BPP_8  = 6'd8;
	localparam logic [5:0] BPP_16 = 6'd16;
	localparam logic [5:0] BPP_24 = 6'd24;
	localparam logic [5:0] BPP_32 = 6'd32;

	// Input opcodes
	localparam logic OP_PALETTE = 1'b0;
	localparam logic OP_DATA    = 1'b1;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_INDEX,
		ERR_NO_PALETTE,
		ERR_DEPTH
	} err_code_t;

	typedef enum logic [2:0] {
		REG_BPP,
		REG_WIDTH,
		REG_HEIGHT,
		REG_TOP_DOWN,
		REG_COLOR_COUNT
	} cfg_reg_t;

	// One result on its way to the output register
	typedef struct packed {
		logic            from_ram;
		logic [23:0]     rgb;
		logic [15:0]     row;
		logic [15:0]     col;
		err_code_t       err;
		logic            last_item;
		logic            eoi;
	} pix_meta_t;

endpackage

/* rtl/brpu_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module brpu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old word on a same-address write; data holds without a read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/bmp_row_pixel_unpacker.sv */
// BMP row pixel unpacker: palette store, byte expander, lookup stage, output register.
// Data bytes wait in the expander; pixels pass the lookup stage, then the output register.
// Throughput: one pixel per cycle unless pixel_stall holds the output; at 1 and 4 bpp each
// pixel of a byte takes one slot through the single palette read port.
// Palette writes share the input channel. Reset (arst_n low) clears counters, errors and
// pipeline, and loads default registers; the palette store is not cleared.
`timescale 1ns / 1ps
`include "bmp_row_pixel_unpacker_macros.svh"

module bmp_row_pixel_unpacker import brpu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input item channel
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        opcode,
	input  logic [7:0]  palette_index,
	input  logic [23:0] palette_word,
	input  logic [7:0]  data_byte,
	// pixel result channel
	output logic        pixel_valid,
	input  logic        pixel_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [15:0] pixel_row,
	output logic [15:0] pixel_column,
	output logic [1:0]  error_code,
	output logic        last_of_item,
	output logic        last_of_image
);

	// Configuration registers
	logic [5:0]  bpp_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic        top_down_q;
	logic [8:0]  color_count_q;

	// Position and assembly state
	logic [17:0] byte_in_row_q;
	logic [15:0] column_q;
	logic [15:0] row_q;
	logic [15:0] partial_q;
	logic [1:0]  bip_q;
	logic        sticky_q;

	// Byte expander
	logic        exp_busy_q;
	logic [7:0]  exp_byte_q;
	logic [2:0]  exp_slot_q;

	// Lookup stage and output register
	logic        valid_s1;
	pix_meta_t   meta_s1;
	pix_meta_t   s1_result;
	logic        out_valid_q;
	pix_meta_t   out_q;

	// Palette RAM ports
	logic                 ram_we;
	logic [PAL_AW-1:0]    ram_waddr;
	logic                 ram_re;
	logic [PAL_WIDTH-1:0] ram_rdata;

	// Derived configuration
	logic [15:0] w_eff;
	logic [15:0] h_eff;
	logic [20:0] row_bits;
	logic [20:0] row_sum31;
	logic [20:0] row_sum7;
	logic [17:0] row_stride;
	logic [17:0] data_bytes;
	err_code_t   cfg_err;
	logic        palette_mode;

	// Expander decisions
	logic [7:0]  idx;
	logic        slot_last;
	logic [16:0] col_plus;
	logic [17:0] bir_inc;
	logic        e_has_res;
	logic        e_finish;
	logic        e_end_upd;
	logic        e_col_inc;
	logic        e_set_sticky;
	logic        e_read;
	logic [15:0] partial_nx;
	logic [1:0]  bip_nx;
	pix_meta_t   e_meta;
	logic [15:0] pix_row;
	logic        pix_eoi;

	// Flow control
	logic out_free;
	logic s1_move;
	logic s1_free;
	logic e_go;
	logic e_done;
	logic item_take;
	logic cfg_take;
	logic cfg_restart;

	// Effective sizes; zero acts as one
	assign w_eff = (width_q == '0) ? 16'd1 : width_q;
	assign h_eff = (height_q == '0) ? 16'd1 : height_q;

	// Row size in bits for the supported depths
	always_comb begin
		case (bpp_q)
			BPP_1:   row_bits = {5'b0, w_eff};
			BPP_4:   row_bits = {3'b0, w_eff, 2'b0};
			BPP_8:   row_bits = {2'b0, w_eff, 3'b0};
			BPP_16:  row_bits = {1'b0, w_eff, 4'b0};
			BPP_24:  row_bits = {1'b0, w_eff, 4'b0} + {2'b0, w_eff, 3'b0};
			BPP_32:  row_bits = {w_eff, 5'b0};
			default: row_bits = '0;
		endcase
	end

	// Stored row length rounds to four bytes; data bytes round to one byte
	assign row_sum31  = row_bits + 21'd31;
	assign row_sum7   = row_bits + 21'd7;
	assign row_stride = {row_sum31[20:5], 2'b00};
	assign data_bytes = row_sum7[20:3];

	// Configuration check: depth first, then missing palette
	always_comb begin
		case (bpp_q)
			BPP_1, BPP_4, BPP_8: begin
				cfg_err      = (color_count_q == '0) ? ERR_NO_PALETTE : ERR_NONE;
				palette_mode = 1'b1;
			end
			BPP_16, BPP_24, BPP_32: begin
				cfg_err      = ERR_NONE;
				palette_mode = 1'b0;
			end
			default: begin
				cfg_err      = ERR_DEPTH;
				palette_mode = 1'b0;
			end
		endcase
	end

	// Current index sits in the top bits of the shifting byte
	always_comb begin
		case (bpp_q)
			BPP_1: begin
				idx       = {7'b0, exp_byte_q[7]};
				slot_last = (exp_slot_q == 3'd7);
			end
			BPP_4: begin
				idx       = {4'b0, exp_byte_q[7:4]};
				slot_last = (exp_slot_q == 3'd1);
			end
			default: begin
				idx       = exp_byte_q;
				slot_last = 1'b1;
			end
		endcase
	end

	assign col_plus = {1'b0, column_q} + 17'd1;
	assign bir_inc  = byte_in_row_q + 18'd1;
	assign pix_row  = top_down_q ? row_q : (h_eff - 16'd1 - row_q);
	assign pix_eoi  = (row_q == h_eff - 16'd1) && (column_q == w_eff - 16'd1);

	// Decide what the expander does with the current slot
	always_comb begin
		e_has_res    = 1'b0;
		e_finish     = 1'b0;
		e_end_upd    = 1'b0;
		e_col_inc    = 1'b0;
		e_set_sticky = 1'b0;
		e_read       = 1'b0;
		partial_nx   = partial_q;
		bip_nx       = bip_q;
		e_meta       = '0;
		e_meta.err   = ERR_NONE;
		if (cfg_err != ERR_NONE || sticky_q) begin
			// error result, counters stay
			e_has_res        = 1'b1;
			e_finish         = 1'b1;
			e_meta.err       = (cfg_err != ERR_NONE) ? cfg_err : ERR_INDEX;
			e_meta.last_item = 1'b1;
		end else if (palette_mode) begin
			if (column_q >= w_eff) begin
				// padding byte past the row's pixels
				e_finish  = 1'b1;
				e_end_upd = 1'b1;
			end else if ({1'b0, idx} >= color_count_q
					|| {1'b0, idx} >= 9'(PALETTE_DEPTH)) begin
				// bad index ends the byte without advancing the row
				e_has_res        = 1'b1;
				e_finish         = 1'b1;
				e_set_sticky     = 1'b1;
				e_meta.err       = ERR_INDEX;
				e_meta.last_item = 1'b1;
			end else begin
				e_has_res        = 1'b1;
				e_read           = 1'b1;
				e_col_inc        = 1'b1;
				e_meta.from_ram  = 1'b1;
				e_meta.row       = pix_row;
				e_meta.col       = column_q;
				e_meta.eoi       = pix_eoi;
				e_meta.last_item = slot_last || (col_plus == {1'b0, w_eff});
				e_finish         = e_meta.last_item;
				e_end_upd        = e_meta.last_item;
			end
		end else begin
			e_finish  = 1'b1;
			e_end_upd = 1'b1;
			if (byte_in_row_q < data_bytes) begin
				// assemble direct-color pixels byte by byte
				case (bip_q)
					2'd0: begin
						partial_nx = {8'b0, exp_byte_q};
						bip_nx     = 2'd1;
					end
					2'd1: begin
						if (bpp_q == BPP_16) begin
							e_has_res  = 1'b1;
							e_meta.rgb = {exp_byte_q[6:2], 3'b0,
								exp_byte_q[1:0], partial_q[7:5], 3'b0,
								partial_q[4:0], 3'b0};
							bip_nx     = 2'd0;
						end else begin
							partial_nx = {exp_byte_q, partial_q[7:0]};
							bip_nx     = 2'd2;
						end
					end
					2'd2: begin
						e_has_res  = 1'b1;
						e_meta.rgb = {exp_byte_q, partial_q};
						bip_nx     = (bpp_q == BPP_32) ? 2'd3 : 2'd0;
					end
					default: begin
						bip_nx = 2'd0;
					end
				endcase
				if (e_has_res) begin
					e_col_inc        = 1'b1;
					e_meta.row       = pix_row;
					e_meta.col       = column_q;
					e_meta.eoi       = pix_eoi;
					e_meta.last_item = 1'b1;
				end
			end
		end
	end

	// Handshake chain from the output back to the input
	assign out_free   = !out_valid_q || !pixel_stall;
	assign s1_move    = valid_s1 && out_free;
	assign s1_free    = !valid_s1 || out_free;
	assign e_go       = exp_busy_q && s1_free;
	assign e_done     = e_go && e_finish;
	assign item_stall = exp_busy_q && !e_done;
	assign item_take  = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;
	assign cfg_take   = cfg_valid && cfg_ready;
	assign cfg_restart = cfg_take && (cfg_index <= REG_COLOR_COUNT);

	// Palette store
	assign ram_we    = item_take && (opcode == OP_PALETTE)
		&& ({1'b0, palette_index} < 9'(PALETTE_DEPTH));
	assign ram_waddr = palette_index[PAL_AW-1:0];
	assign ram_re    = e_go && e_read;

	brpu_ram #(
		.WIDTH (PAL_WIDTH),
		.DEPTH (PALETTE_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (palette_word),
		.re    (ram_re),
		.raddr (idx[PAL_AW-1:0]),
		.rdata (ram_rdata)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q         <= BPP_24;
			width_q       <= 16'd1;
			height_q      <= 16'd1;
			top_down_q    <= 1'b0;
			color_count_q <= '0;
		end else if (cfg_take) begin
			case (cfg_index)
				REG_BPP:         bpp_q         <= cfg_data[5:0];
				REG_WIDTH:       width_q       <= cfg_data;
				REG_HEIGHT:      height_q      <= cfg_data;
				REG_TOP_DOWN:    top_down_q    <= cfg_data[0];
				REG_COLOR_COUNT: color_count_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// Position counters, pixel assembly and sticky error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_in_row_q <= '0;
			column_q      <= '0;
			row_q         <= '0;
			partial_q     <= '0;
			bip_q         <= '0;
			sticky_q      <= 1'b0;
		end else if (cfg_restart) begin
			byte_in_row_q <= '0;
			column_q      <= '0;
			row_q         <= '0;
			partial_q     <= '0;
			bip_q         <= '0;
			sticky_q      <= 1'b0;
		end else if (e_go) begin
			if (e_set_sticky) begin
				sticky_q <= 1'b1;
			end
			partial_q <= partial_nx;
			bip_q     <= bip_nx;
			if (e_col_inc) begin
				column_q <= col_plus[15:0];
			end
			if (e_end_upd) begin
				if (bir_inc >= row_stride) begin
					// row done, padding consumed
					byte_in_row_q <= '0;
					column_q      <= '0;
					bip_q         <= '0;
					partial_q     <= '0;
					row_q         <= (row_q + 16'd1 >= h_eff) ? 16'd0 : row_q + 16'd1;
				end else begin
					byte_in_row_q <= bir_inc;
				end
			end
		end
	end

	// Expander control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_busy_q <= 1'b0;
			exp_slot_q <= '0;
		end else begin
			if (e_go) begin
				if (e_finish) begin
					exp_busy_q <= 1'b0;
				end else begin
					exp_slot_q <= exp_slot_q + 3'd1;
				end
			end
			if (item_take && opcode == OP_DATA) begin
				exp_busy_q <= 1'b1;
				exp_slot_q <= '0;
			end
		end
	end

	// Expander byte: load on accept, shift out one index per slot
	always_ff @(posedge clk) begin
		if (item_take && opcode == OP_DATA) begin
			exp_byte_q <= data_byte;
		end else if (e_go && !e_finish) begin
			exp_byte_q <= (bpp_q == BPP_1) ? {exp_byte_q[6:0], 1'b0}
				: {exp_byte_q[3:0], 4'b0};
		end
	end

	// Lookup stage and output register valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= e_go && e_has_res;
			end
			if (out_free) begin
				out_valid_q <= s1_move;
			end
		end
	end

	// Merge the palette word into the lookup stage result
	always_comb begin
		s1_result     = meta_s1;
		s1_result.rgb = meta_s1.from_ram ? ram_rdata : meta_s1.rgb;
	end

	// Lookup stage and output register payload
	always_ff @(posedge clk) begin
		if (s1_free) begin
			meta_s1 <= e_meta;
		end
		if (s1_move) begin
			out_q <= s1_result;
		end
	end

	assign pixel_valid   = out_valid_q;
	assign red           = out_q.rgb[23:16];
	assign green         = out_q.rgb[15:8];
	assign blue          = out_q.rgb[7:0];
	assign pixel_row     = out_q.row;
	assign pixel_column  = out_q.col;
	assign error_code    = out_q.err;
	assign last_of_item  = out_q.last_item;
	assign last_of_image = out_q.eoi;

	// Error results carry no position and always close their byte
	`BRPU_ASSERT_IMPLY(a_err_bare, pixel_valid && error_code != ERR_NONE, last_of_item && pixel_row == '0 && pixel_column == '0 && !last_of_image, "error result with position or not last")
	// The last pixel of an image is always the last result of its byte
	`BRPU_ASSERT_IMPLY(a_eoi_last, pixel_valid && last_of_image, last_of_item, "end of image not last of byte")
	// A blocked lookup stage keeps its result
	`BRPU_ASSERT_NEXT(a_s1_hold, valid_s1 && !out_free, valid_s1 && $stable(meta_s1), "lookup stage lost a blocked result")

endmodule

/* test/bmp_row_pixel_unpacker_checker.sv */
// Checker for the BMP row pixel unpacker: shadows settings and palette, predicts pixels, compares.
`timescale 1ns / 1ps

module brpu_pixel_checker import brpu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        item_valid,
	input  logic        item_stall,
	input  logic        opcode,
	input  logic [7:0]  palette_index,
	input  logic [23:0] palette_word,
	input  logic [7:0]  data_byte,
	input  logic        pixel_valid,
	input  logic        pixel_stall,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [15:0] pixel_row,
	input  logic [15:0] pixel_column,
	input  logic [1:0]  error_code,
	input  logic        last_of_item,
	input  logic        last_of_image,
	output int          mismatch_count,
	output int          pixels_pending,
	output int          pixels_checked,
	output int          faults_checked
);

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] row;
		logic [15:0] col;
		err_code_t   err;
		logic        last_item;
		logic        eoi;
	} rgb_pixel_t;

	// Keep the log short when the block is badly broken
	localparam int REPORT_LINES = 25;

	// Shadow copy of the block's settings and state
	logic [23:0] palette_shadow [PALETTE_DEPTH];
	logic [5:0]  depth;
	logic [15:0] width_reg;
	logic [15:0] height_reg;
	logic        top_down;
	logic [8:0]  color_count;
	int unsigned byte_in_row;
	int unsigned column_count;
	int unsigned row_count;
	logic [15:0] partial_pixel;
	int unsigned bytes_in_pixel;
	logic        index_fault;

	rgb_pixel_t  pixel_expect_q[$];
	int          mismatches = 0;
	int          pixels_seen = 0;
	int          faults_seen = 0;

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < REPORT_LINES)
			$display("%0t: %s mismatch: got %0h, want %0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic restart_image();
		byte_in_row = 0;
		column_count = 0;
		row_count = 0;
		partial_pixel = '0;
		bytes_in_pixel = 0;
		index_fault = 1'b0;
	endtask

	// Any known register write restarts the image and clears the sticky fault
	task automatic apply_register(input logic [2:0] idx, input logic [15:0] value);
		case (idx)
		REG_BPP:         depth = value[5:0];
		REG_WIDTH:       width_reg = value;
		REG_HEIGHT:      height_reg = value;
		REG_TOP_DOWN:    top_down = value[0];
		REG_COLOR_COUNT: color_count = value[8:0];
		default:         return;
		endcase
		restart_image();
	endtask

	task automatic push_pixel(input logic [23:0] rgb, input int unsigned w,
			input int unsigned h);
		rgb_pixel_t p;
		p.red = rgb[23:16];
		p.green = rgb[15:8];
		p.blue = rgb[7:0];
		p.row = top_down ? 16'(row_count) : 16'(h - 1 - row_count);
		p.col = 16'(column_count);
		p.err = ERR_NONE;
		p.last_item = 1'b0;
		p.eoi = (row_count == h - 1) && (column_count == w - 1);
		pixel_expect_q.push_back(p);
		column_count++;
	endtask

	task automatic push_fault(input err_code_t err);
		rgb_pixel_t p;
		p = '0;
		p.err = err;
		p.last_item = 1'b1;
		pixel_expect_q.push_back(p);
	endtask

	// Predict every result of one bitmap byte and advance the row position
	task automatic unpack_byte(input logic [7:0] d);
		int unsigned w, h, bpp, row_stride, data_bytes, per, idx, produced;
		err_code_t   fault;
		logic [15:0] px;
		rgb_pixel_t  last;
		w = (width_reg == 0) ? 1 : width_reg;
		h = (height_reg == 0) ? 1 : height_reg;
		bpp = depth;
		produced = 0;

		// Depth is checked before the palette, the sticky fault last
		case (depth)
		BPP_1, BPP_4, BPP_8:    fault = (color_count == 0) ? ERR_NO_PALETTE : ERR_NONE;
		BPP_16, BPP_24, BPP_32: fault = ERR_NONE;
		default:                fault = ERR_DEPTH;
		endcase
		if (fault == ERR_NONE && index_fault)
			fault = ERR_INDEX;
		if (fault != ERR_NONE) begin
			push_fault(fault);
			return;
		end

		row_stride = ((w * bpp + 31) / 32) * 4;
		data_bytes = (w * bpp + 7) / 8;

		if (bpp <= 8) begin
			// Palette modes: indices from the top bits down, stop at the row end
			per = 8 / bpp;
			for (int i = 0; i < per && column_count < w; i++) begin
				idx = (d >> (8 - bpp * (i + 1))) & ((1 << bpp) - 1);
				if (idx >= color_count) begin
					index_fault = 1'b1;
					push_fault(ERR_INDEX);
					return;
				end
				push_pixel(palette_shadow[idx], w, h);
				produced++;
			end
		end else if (byte_in_row < data_bytes) begin
			if (bpp == 16) begin
				// 5-5-5, little endian, top bit dropped
				if (bytes_in_pixel == 0) begin
					partial_pixel = {8'h00, d};
					bytes_in_pixel = 1;
				end else begin
					px = {d, partial_pixel[7:0]};
					push_pixel({px[14:10], 3'b000, px[9:5], 3'b000, px[4:0], 3'b000}, w, h);
					produced++;
					bytes_in_pixel = 0;
				end
			end else begin
				// Blue, green, red, and a skipped fourth byte at 32 bpp
				case (bytes_in_pixel)
				0: begin
					partial_pixel = {8'h00, d};
					bytes_in_pixel = 1;
				end
				1: begin
					partial_pixel = {d, partial_pixel[7:0]};
					bytes_in_pixel = 2;
				end
				2: begin
					push_pixel({d, partial_pixel}, w, h);
					produced++;
					bytes_in_pixel = (bpp == 32) ? 3 : 0;
				end
				default: bytes_in_pixel = 0;
				endcase
			end
		end

		// Advance past data and padding; wrap rows after the last one
		byte_in_row++;
		if (byte_in_row >= row_stride) begin
			byte_in_row = 0;
			column_count = 0;
			bytes_in_pixel = 0;
			partial_pixel = '0;
			row_count++;
			if (row_count >= h)
				row_count = 0;
		end

		if (produced > 0) begin
			last = pixel_expect_q.pop_back();
			last.last_item = 1'b1;
			pixel_expect_q.push_back(last);
		end
	endtask

	task automatic check_result();
		rgb_pixel_t want;
		if (pixel_expect_q.size() == 0) begin
			flag_mismatch("unexpected result transaction, column", pixel_column, 0);
			return;
		end
		want = pixel_expect_q.pop_front();
		if (red !== want.red)
			flag_mismatch("red", red, want.red);
		if (green !== want.green)
			flag_mismatch("green", green, want.green);
		if (blue !== want.blue)
			flag_mismatch("blue", blue, want.blue);
		if (pixel_row !== want.row)
			flag_mismatch("pixel_row", pixel_row, want.row);
		if (pixel_column !== want.col)
			flag_mismatch("pixel_column", pixel_column, want.col);
		if (error_code !== want.err)
			flag_mismatch("error_code", error_code, want.err);
		if (last_of_item !== want.last_item)
			flag_mismatch("last_of_item", last_of_item, want.last_item);
		if (last_of_image !== want.eoi)
			flag_mismatch("last_of_image", last_of_image, want.eoi);
		if (want.err == ERR_NONE)
			pixels_seen++;
		else
			faults_seen++;
	endtask

	// Compare the result transaction first: it never stems from this edge's input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth = BPP_24;
			width_reg = 16'd1;
			height_reg = 16'd1;
			top_down = 1'b0;
			color_count = 9'd0;
			restart_image();
			pixel_expect_q.delete();
		end else begin
			if (pixel_valid && !pixel_stall)
				check_result();
			if (cfg_valid && cfg_ready)
				apply_register(cfg_index, cfg_data);
			if (item_valid && !item_stall) begin
				if (opcode == OP_PALETTE)
					palette_shadow[palette_index] = palette_word;
				else
					unpack_byte(data_byte);
			end
		end
		mismatch_count <= mismatches;
		pixels_pending <= pixel_expect_q.size();
		pixels_checked <= pixels_seen;
		faults_checked <= faults_seen;
	end

endmodule

/* test/tb_bmp_row_pixel_unpacker.sv */
// Testbench top for the BMP row pixel unpacker: reset, stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_bmp_row_pixel_unpacker;
	import brpu_pkg::*;

	localparam int RANDOM_BYTES   = 130;
	localparam int PALETTE_FILL   = 64;
	localparam int IDLE_PERCENT   = 22;
	localparam int SETTLE_CYCLES  = 24;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 2000;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        item_valid;
	logic        item_stall;
	logic        opcode;
	logic [7:0]  palette_index;
	logic [23:0] palette_word;
	logic [7:0]  data_byte;
	logic        pixel_valid;
	logic        pixel_stall;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [15:0] pixel_row;
	logic [15:0] pixel_column;
	logic [1:0]  error_code;
	logic        last_of_item;
	logic        last_of_image;

	int mismatch_count;
	int pixels_pending;
	int pixels_checked;
	int faults_checked;

	logic calm = 1'b0;
	int   items_sent = 0;
	int   settings_applied = 0;
	int   idle_cycles = 0;

	bmp_row_pixel_unpacker u_dut (.*);

	brpu_pixel_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Random back-pressure on the result side, none while calm
	initial begin
		pixel_stall = 1'b0;
		forever begin
			@(negedge clk);
			pixel_stall = !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (pixel_valid && !pixel_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one transaction at the falling edge and hold it until accepted
	task automatic send_item(input logic op, input logic [7:0] pidx,
			input logic [23:0] pword, input logic [7:0] dbyte);
		while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		opcode = op;
		palette_index = pidx;
		palette_word = pword;
		data_byte = dbyte;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] d);
		send_item(OP_DATA, 8'($urandom), 24'($urandom), d);
	endtask

	// Send bytes from the low end of a word, first byte in bits 7..0
	task automatic send_bytes(input logic [31:0] bytes, input int count);
		for (int i = 0; i < count; i++)
			send_byte(bytes[8*i +: 8]);
	endtask

	task automatic write_register(input cfg_reg_t idx, input logic [15:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drain the block, then write all five registers; noisy fills unused data bits
	task automatic load_setting(input logic [5:0] bpp, input logic [15:0] w,
			input logic [15:0] h, input logic td, input logic [8:0] cc, input logic noisy);
		logic [15:0] pad;
		item_valid = 1'b0;
		while (pixels_pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		pad = noisy ? 16'($urandom) : 16'h0000;
		write_register(REG_BPP, {pad[15:6], bpp});
		write_register(REG_WIDTH, w);
		write_register(REG_HEIGHT, h);
		write_register(REG_TOP_DOWN, {pad[15:1], td});
		write_register(REG_COLOR_COUNT, {pad[15:9], cc});
		cfg_valid = 1'b0;
		settings_applied++;
	endtask

	initial begin
		int unsigned bpp, w, h, w_eff, h_eff, row_stride, image_bytes, count, sent, pick;
		logic [8:0]  cc;
		logic        odd_depth;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_BPP;
		cfg_data = 16'h0000;
		item_valid = 1'b0;
		opcode = OP_DATA;
		palette_index = 8'h00;
		palette_word = 24'h000000;
		data_byte = 8'h00;
		sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Load the low palette entries; every later lookup stays below them
		for (int i = 0; i < PALETTE_FILL; i++)
			send_item(OP_PALETTE, 8'(i),
				(i == 0) ? 24'h000000 : (i == 1) ? 24'hFFFFFF : 24'($urandom),
				8'($urandom));

		// Reset setting: 24 bpp, one pixel, padded to four bytes
		send_bytes(32'hFF5A_FF00, 4);
		// 1 bpp, nine pixels cross a byte, bottom-up rows
		load_setting(BPP_1, 16'd9, 16'd2, 1'b0, 9'd2, 1'b0);
		send_bytes(32'h00FF_80A5, 4);
		// 4 bpp with a short palette: pixel, then index fault, then sticky fault
		load_setting(BPP_4, 16'd3, 16'd1, 1'b1, 9'd10, 1'b0);
		send_bytes(32'h0000_000F, 2);
		// 8 bpp, full palette, lowest and highest loaded index
		load_setting(BPP_8, 16'd2, 16'd1, 1'b1, 9'd256, 1'b0);
		send_bytes(32'h0000_003F, 2);
		// 16 bpp, all ones and top bit only
		load_setting(BPP_16, 16'd2, 16'd1, 1'b1, 9'd0, 1'b0);
		send_bytes(32'h8000_7FFF, 4);
		// 32 bpp, fourth byte skipped
		load_setting(BPP_32, 16'd1, 16'd1, 1'b0, 9'd0, 1'b0);
		send_bytes(32'hFF56_3412, 4);
		// Palette depth with no palette, then unsupported depths
		load_setting(BPP_8, 16'd1, 16'd1, 1'b0, 9'd0, 1'b0);
		send_byte(8'h00);
		load_setting(6'h3F, 16'd1, 16'd1, 1'b0, 9'd2, 1'b0);
		send_byte(8'hFF);
		load_setting(6'h00, 16'd1, 16'd1, 1'b0, 9'd2, 1'b0);
		send_byte(8'h00);
		// Zero sizes act as one
		load_setting(BPP_24, 16'd0, 16'd0, 1'b0, 9'd0, 1'b0);
		send_bytes(32'h00AB_CDEF, 3);
		// Widest and tallest image, first bytes only
		load_setting(BPP_1, 16'hFFFF, 16'hFFFF, 1'b0, 9'd2, 1'b0);
		send_bytes(32'h0000_A55A, 2);
		// Color count beyond the palette store
		load_setting(BPP_8, 16'd1, 16'd1, 1'b1, 9'd511, 1'b1);
		send_byte(8'h3F);

		// Random images: mostly complete, some cut short or run into the next
		for (int phase = 0; sent < RANDOM_BYTES; phase++) begin
			calm = (phase >= 2 && phase < 6);
			odd_depth = ($urandom_range(0, 99) < 8);
			if (odd_depth) begin
				bpp = $urandom_range(0, 63);
			end else begin
				case ($urandom_range(0, 5))
				0:       bpp = BPP_1;
				1:       bpp = BPP_4;
				2:       bpp = BPP_8;
				3:       bpp = BPP_16;
				4:       bpp = BPP_24;
				default: bpp = BPP_32;
				endcase
			end
			w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
			h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3);

			// Mostly a complete palette, sometimes a short or missing one
			pick = $urandom_range(0, 99);
			if (bpp > 8)
				cc = 9'($urandom_range(0, 511));
			else if (pick < 55)
				cc = 9'(1 << bpp);
			else if (pick < 70)
				cc = 9'($urandom_range(1 << bpp, 511));
			else if (pick < 92)
				cc = 9'($urandom_range(1, (1 << bpp) - 1));
			else
				cc = 9'd0;
			load_setting(6'(bpp), 16'(w), 16'(h), 1'($urandom), cc, 1'b1);

			w_eff = (w == 0) ? 1 : w;
			h_eff = (h == 0) ? 1 : h;
			row_stride = ((w_eff * bpp + 31) / 32) * 4;
			image_bytes = row_stride * h_eff;
			pick = $urandom_range(0, 99);
			if (odd_depth || image_bytes == 0)
				count = $urandom_range(1, 4);
			else if (pick < 70)
				count = image_bytes;
			else if (pick < 85)
				count = image_bytes + $urandom_range(1, 4);
			else
				count = $urandom_range(1, image_bytes);

			// At 8 bpp keep indices inside the loaded entries
			for (int i = 0; i < count; i++) begin
				if ($urandom_range(0, 99) < 4)
					send_item(OP_PALETTE, 8'($urandom), 24'($urandom), 8'($urandom));
				if (bpp == 8)
					send_byte(8'($urandom_range(0, PALETTE_FILL - 1)));
				else
					send_byte(8'($urandom));
				sent++;
			end
		end
		calm = 1'b0;

		// Wait for the last results, then let the pipeline run dry
		item_valid = 1'b0;
		while (pixels_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Covered %0d input transactions over %0d settings: all depths, faults, sizes.",
			items_sent, settings_applied);
		$display("Checked %0d pixels and %0d fault results.", pixels_checked, faults_checked);
		if (mismatch_count == 0 && pixels_pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
